[rtl/epd_lsf_pkg.sv]
// Shared constants and pixel recoding functions for the e-paper line stream
// formatter. No dependencies; used by epd_line_stream_formatter_top.
`default_nettype none

package epd_lsf_pkg;

    // Input command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_SEND  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_STAGE_MODE = 2'd0;
    localparam logic [1:0] CFG_USE_FIXED  = 2'd1;
    localparam logic [1:0] CFG_FIXED_BYTE = 2'd2;

    // Stage modes
    localparam logic [1:0] STAGE_COMPENSATE = 2'd0;
    localparam logic [1:0] STAGE_WHITE      = 2'd1;
    localparam logic [1:0] STAGE_INVERSE    = 2'd2;
    localparam logic [1:0] STAGE_NORMAL     = 2'd3;

    // Fixed bytes of the panel sequence
    localparam logic [7:0] BYTE_CMD_INDEX = 8'h70;
    localparam logic [7:0] BYTE_CMD_DATA  = 8'h72;
    localparam logic [7:0] BYTE_REG_DATA  = 8'h0a;
    localparam logic [7:0] BYTE_BORDER    = 8'h00;
    localparam logic [7:0] BYTE_REG_OUT   = 8'h02;
    localparam logic [7:0] BYTE_OUT_ON    = 8'h07;
    localparam logic [7:0] MASK_ODD       = 8'h55;
    localparam logic [7:0] MASK_EVEN      = 8'haa;
    localparam logic [1:0] SCAN_PAIR      = 2'b11;

    // Recode the odd pixels of a buffer byte
    function automatic logic [7:0] recode_odd(input logic [7:0] raw, input logic [1:0] mode);
        logic [7:0] p;
        logic [7:0] q;
        begin
            p = raw & MASK_ODD;
            q = p ^ MASK_ODD;
            case (mode)
                STAGE_COMPENSATE: recode_odd = MASK_EVEN | q;
                STAGE_WHITE:      recode_odd = MASK_ODD + q;
                STAGE_INVERSE:    recode_odd = MASK_ODD | {q[6:0], 1'b0};
                default:          recode_odd = MASK_EVEN | p;
            endcase
        end
    endfunction

    // Recode the even pixels of a buffer byte and reverse its 2-bit pairs
    function automatic logic [7:0] recode_even(input logic [7:0] raw, input logic [1:0] mode);
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] r;
        begin
            p = raw & MASK_EVEN;
            q = p ^ MASK_EVEN;
            case (mode)
                STAGE_COMPENSATE: r = MASK_EVEN | {1'b0, q[7:1]};
                STAGE_WHITE:      r = MASK_ODD + {1'b0, q[7:1]};
                STAGE_INVERSE:    r = MASK_ODD | q;
                default:          r = MASK_EVEN | {1'b0, p[7:1]};
            endcase
            recode_even = {r[1:0], r[3:2], r[5:4], r[7:6]};
        end
    endfunction

endpackage

`default_nettype wire

[rtl/epd_lsf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the line buffer of the formatter.
`default_nettype none

module epd_lsf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 33,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/epd_line_stream_formatter_top.sv]
// Top level of the e-paper line stream formatter: command decode, sequence
// position, line buffer and byte formatting. Depends on epd_lsf_pkg, epd_lsf_ram.
`default_nettype none

// The block takes one command per cycle: start (latch the line number and
// rewind the sequence), load (store the next image byte in the line buffer)
// or send (emit the next byte of the panel sequence). A send reaches the
// output through the first stage and the output register: the line buffer
// sits in a RAM with a registered read port, which forms the first stage,
// and the formatted byte is held in an output register. While the output
// is stalled one further send waits in the first stage and the input stalls
// behind it; otherwise one command is taken every cycle. A send after the
// sequence has finished, and command code 3, give nothing. The sequence of
// one line is 8 + 2*(PIXELS_PER_LINE/8) + LINES_PER_FRAME/4 bytes long.
module epd_line_stream_formatter_top #(
    parameter int PIXELS_PER_LINE = 264,
    parameter int LINES_PER_FRAME = 176
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Command channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_line_number,
    input  wire logic [7:0] i_pixel_byte,
    // Byte channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [7:0] o_spi_byte,
    output logic            o_frame_end,
    output logic            o_line_done,
    // Configuration channel
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    localparam int NBYTES     = PIXELS_PER_LINE / 8;
    localparam int NSCAN      = LINES_PER_FRAME / 4;
    localparam int ODD_START  = 4;
    localparam int SCAN_START = ODD_START + NBYTES;
    localparam int EVEN_START = SCAN_START + NSCAN;
    localparam int TAIL_START = EVEN_START + NBYTES;
    localparam int SEQ_LEN    = TAIL_START + 4;
    localparam int POS_W      = $clog2(SEQ_LEN + 1);
    localparam int AW         = (NBYTES > 1) ? $clog2(NBYTES) : 1;
    localparam int G_W        = (POS_W > 6) ? POS_W : 6;

    // Configuration registers
    logic [1:0] r_stage_mode;
    logic       r_use_fixed;
    logic [7:0] r_fixed_byte;

    // Control state
    logic [AW-1:0]    r_load_index;
    logic [POS_W-1:0] r_emit_pos;
    logic [7:0]       r_cur_line;

    // First stage (send waiting for its buffer byte)
    logic             r_s1_valid;
    logic [POS_W-1:0] r_s1_pos;
    logic [7:0]       r_s1_line;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_fe;
    logic       r_out_done;

    logic             w_in_xfer;
    logic             w_cfg_xfer;
    logic             w_s1_adv;
    logic             w_pending;
    logic             w_send;
    logic             w_load;
    logic             w_start;
    logic [POS_W-1:0] w_addr_full;
    logic [AW-1:0]    w_rd_addr;
    logic [7:0]       w_rd_data;
    logic [G_W-1:0]   w_group;
    logic [7:0]       n_byte;
    logic             n_fe;
    logic             n_done;

    // Handshakes
    assign w_s1_adv    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || w_s1_adv;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_xfer  = i_cfg_valid;

    assign w_pending = (r_emit_pos < POS_W'(SEQ_LEN));
    assign w_start   = w_in_xfer && (i_command == epd_lsf_pkg::CMD_START);
    assign w_load    = w_in_xfer && (i_command == epd_lsf_pkg::CMD_LOAD);
    assign w_send    = w_in_xfer && (i_command == epd_lsf_pkg::CMD_SEND) && w_pending;

    // Buffer address: odd bytes run backwards, even bytes forwards
    always_comb begin
        if (r_emit_pos >= POS_W'(EVEN_START)) begin
            w_addr_full = r_emit_pos - POS_W'(EVEN_START);
        end else begin
            w_addr_full = POS_W'(NBYTES - 1 + ODD_START) - r_emit_pos;
        end
    end
    assign w_rd_addr = w_addr_full[AW-1:0];

    epd_lsf_ram #(
        .WIDTH (8),
        .DEPTH (NBYTES),
        .ADDR_W(AW)
    ) u_line_buf (
        .i_clk    (i_clk),
        .i_wr_en  (w_load),
        .i_wr_addr(r_load_index),
        .i_wr_data(i_pixel_byte),
        .i_rd_en  (w_send),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_mode <= 2'd0;
            r_use_fixed  <= 1'b0;
            r_fixed_byte <= 8'd0;
        end else if (w_cfg_xfer) begin
            case (i_cfg_index)
                epd_lsf_pkg::CFG_STAGE_MODE: r_stage_mode <= i_cfg_data[1:0];
                epd_lsf_pkg::CFG_USE_FIXED:  r_use_fixed  <= i_cfg_data[0];
                epd_lsf_pkg::CFG_FIXED_BYTE: r_fixed_byte <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Command handling: rewind, load pointer, sequence advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_index <= '0;
            r_emit_pos   <= POS_W'(SEQ_LEN);
            r_cur_line   <= 8'd0;
        end else if (w_start) begin
            r_load_index <= '0;
            r_emit_pos   <= '0;
            r_cur_line   <= i_line_number;
        end else if (w_load) begin
            if (r_load_index == AW'(NBYTES - 1)) begin
                r_load_index <= '0;
            end else begin
                r_load_index <= r_load_index + AW'(1);
            end
        end else if (w_send) begin
            r_emit_pos <= r_emit_pos + POS_W'(1);
        end
    end

    // First stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_send) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // First stage payload: hold position and line of the send
    always_ff @(posedge i_clk) begin
        if (w_send) begin
            r_s1_pos  <= r_emit_pos;
            r_s1_line <= r_cur_line;
        end
    end

    // Scan group that the byte at this position stands for
    assign w_group = G_W'(EVEN_START - 1) - G_W'(r_s1_pos);

    // Format the byte for the position in the first stage
    always_comb begin
        n_byte = epd_lsf_pkg::BYTE_BORDER;
        n_fe   = 1'b0;
        n_done = 1'b0;
        if (r_s1_pos == POS_W'(0)) begin
            n_byte = epd_lsf_pkg::BYTE_CMD_INDEX;
        end else if (r_s1_pos == POS_W'(1)) begin
            n_byte = epd_lsf_pkg::BYTE_REG_DATA;
            n_fe   = 1'b1;
        end else if (r_s1_pos == POS_W'(2)) begin
            n_byte = epd_lsf_pkg::BYTE_CMD_DATA;
        end else if (r_s1_pos == POS_W'(3)) begin
            n_byte = epd_lsf_pkg::BYTE_BORDER;
        end else if (r_s1_pos < POS_W'(SCAN_START)) begin
            n_byte = r_use_fixed ? r_fixed_byte
                                 : epd_lsf_pkg::recode_odd(w_rd_data, r_stage_mode);
        end else if (r_s1_pos < POS_W'(EVEN_START)) begin
            if ((r_s1_line < 8'(LINES_PER_FRAME)) && (G_W'(r_s1_line[7:2]) == w_group)) begin
                n_byte = 8'(epd_lsf_pkg::SCAN_PAIR) << {r_s1_line[1:0], 1'b0};
            end else begin
                n_byte = 8'd0;
            end
        end else if (r_s1_pos < POS_W'(TAIL_START)) begin
            n_byte = r_use_fixed ? r_fixed_byte
                                 : epd_lsf_pkg::recode_even(w_rd_data, r_stage_mode);
            n_fe   = (r_s1_pos == POS_W'(TAIL_START - 1));
        end else if (r_s1_pos == POS_W'(TAIL_START)) begin
            n_byte = epd_lsf_pkg::BYTE_CMD_INDEX;
        end else if (r_s1_pos == POS_W'(TAIL_START + 1)) begin
            n_byte = epd_lsf_pkg::BYTE_REG_OUT;
            n_fe   = 1'b1;
        end else if (r_s1_pos == POS_W'(TAIL_START + 2)) begin
            n_byte = epd_lsf_pkg::BYTE_CMD_DATA;
        end else begin
            n_byte = epd_lsf_pkg::BYTE_OUT_ON;
            n_fe   = 1'b1;
            n_done = 1'b1;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_byte <= n_byte;
            r_out_fe   <= n_fe;
            r_out_done <= n_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_spi_byte  = r_out_byte;
    assign o_frame_end = r_out_fe;
    assign o_line_done = r_out_done;

    // The sequence position never runs past its end
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_pos <= POS_W'(SEQ_LEN))
        else $error("sequence position beyond end");

    // The load pointer stays inside the buffer
    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_index <= AW'(NBYTES - 1))
        else $error("load pointer beyond buffer");

    // A pending send always reaches the first stage
    a_send_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_send |=> r_s1_valid && (r_s1_pos == $past(r_emit_pos)))
        else $error("send not staged");

    // The last byte of the line also closes its frame
    a_done_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_fe && (r_out_byte == epd_lsf_pkg::BYTE_OUT_ON))
        else $error("line end without frame end");

endmodule

`default_nettype wire
